/* hw/rtl/scalar_field_colormap_shader_defines.svh */
// ----------------------------------------------------------------------------
// Scalar field colormap shader assertion macros
// Shared property shorthands for the shader's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SCALAR_FIELD_COLORMAP_SHADER_DEFINES_SVH
`define SCALAR_FIELD_COLORMAP_SHADER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SFCS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SFCS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sfcs_pkg.sv */
// ----------------------------------------------------------------------------
// Scalar field colormap shader package
// Widths, register indexes, payload structs and the smoke scaling table.
// ----------------------------------------------------------------------------
package sfcs_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int COLOR_WIDTH     = 8;
    localparam int SMOKE_WIDTH     = 8;
    localparam int NORM_BITS       = COLOR_WIDTH + 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int EPS_LSB         = 7;
    localparam int CMAX            = (1 << COLOR_WIDTH) - 1;
    localparam int SMOKE_FULL      = (1 << SMOKE_WIDTH) - 1;
    localparam int SMOKE_ENTRIES   = 1 << SMOKE_WIDTH;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MIN_LEVEL     = 2'd0,
        CFG_MAX_LEVEL     = 2'd1,
        CFG_SHOW_PRESSURE = 2'd2,
        CFG_SHOW_SMOKE    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] pressure_value;
        logic [SMOKE_WIDTH-1:0]        smoke_level;
        logic                          solid_cell;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_WIDTH-1:0] red;
        logic [COLOR_WIDTH-1:0] green;
        logic [COLOR_WIDTH-1:0] blue;
    } out_item_t;

    typedef logic [COLOR_WIDTH-1:0] smoke_lut_t [SMOKE_ENTRIES];

    // Smoke density 0..SMOKE_FULL rescaled to channel full scale, rounded down.
    function automatic smoke_lut_t build_smoke_lut();
        smoke_lut_t lut;
        for (int i = 0; i < SMOKE_ENTRIES; i++)
        begin
            lut[i] = COLOR_WIDTH'((i * CMAX) / SMOKE_FULL);
        end
        return lut;
    endfunction

    localparam smoke_lut_t SMOKE_LUT = build_smoke_lut();

endpackage

/* hw/rtl/scalar_field_colormap_shader.sv */
// Throughput: one cell per cycle unless out_ready holds the output stage;
// the restoring divider is unrolled into one stage per bit.
// Stalls collapse bubbles stage by stage, so a held output does not block a free pipe.
// Reset: rst_n clears all valid bits and loads min 0, max 1.0, pressure on, smoke off.
// Config values are not carried with each cell, so a write also affects cells in flight.
// ----------------------------------------------------------------------------
// Scalar field colormap shader
// Maps a Q16.16 pressure cell onto a four-ramp jet colormap with optional
// smoke darkening, smoke grey, or solid/fluid black and white.
// ----------------------------------------------------------------------------
`include "scalar_field_colormap_shader_defines.svh"

module scalar_field_colormap_shader (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [sfcs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sfcs_pkg::VALUE_WIDTH-1:0]     cfg_data,
    // cell input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sfcs_pkg::in_item_t                  in_data,
    // color output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output sfcs_pkg::out_item_t                 out_data
);
    import sfcs_pkg::*;

    // Internal arithmetic width: pressure plus room for span and epsilon.
    localparam int DW = VALUE_WIDTH + 2;
    // Stages: capture, clamp, offset, fold sign, classify, NORM_BITS divide, ramp.
    localparam int DIV_FIRST = 4;
    localparam int NS        = NORM_BITS + 6;

    typedef enum logic [1:0] {
        NORM_DIV,
        NORM_ZERO,
        NORM_TOP,
        NORM_HALF
    } norm_code_t;

    typedef struct packed {
        norm_code_t             code;
        logic [COLOR_WIDTH-1:0] smoke;
        logic                   solid;
    } tail_t;

    // ------------------------------------------------------------------
    // Configuration registers and values derived from them
    // ------------------------------------------------------------------
    logic signed [VALUE_WIDTH-1:0] min_level_reg;
    logic signed [VALUE_WIDTH-1:0] max_level_reg;
    logic                          show_pressure_reg;
    logic                          show_smoke_reg;

    logic signed [DW-1:0] min_ext;
    logic signed [DW-1:0] max_ext;
    logic signed [DW-1:0] span_next;
    logic signed [DW-1:0] hi_reg;
    logic [DW-1:0]        span_abs_reg;
    logic                 span_neg_reg;
    logic                 span_zero_reg;

    assign min_ext   = DW'(min_level_reg);
    assign max_ext   = DW'(max_level_reg);
    assign span_next = max_ext - min_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg     <= '0;
            max_level_reg     <= VALUE_WIDTH'(65536);
            show_pressure_reg <= 1'b1;
            show_smoke_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_LEVEL:     min_level_reg     <= cfg_data;
                CFG_MAX_LEVEL:     max_level_reg     <= cfg_data;
                CFG_SHOW_PRESSURE: show_pressure_reg <= cfg_data[0];
                CFG_SHOW_SMOKE:    show_smoke_reg    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Register the clamp ceiling and span so the cell path sees one add at a time.
    always_ff @(posedge clk)
    begin
        hi_reg        <= max_ext - DW'(EPS_LSB);
        span_neg_reg  <= span_next[DW-1];
        span_zero_reg <= (span_next == '0);
        span_abs_reg  <= span_next[DW-1] ? $unsigned(-span_next) : $unsigned(span_next);
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it drains.
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] load;

    assign load[NS-1] = !valid_reg[NS-1] || out_ready;
    for (genvar k = 0; k < NS - 1; k++)
    begin : g_load
        assign load[k] = !valid_reg[k] || load[k+1];
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Side data rides along every stage but the last.
    tail_t tail_reg [NS-1];

    // ------------------------------------------------------------------
    // Stage 0: capture the cell, scale smoke to channel width
    // ------------------------------------------------------------------
    logic signed [VALUE_WIDTH-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            p_reg             <= in_data.pressure_value;
            tail_reg[0].code  <= NORM_DIV;
            tail_reg[0].smoke <= SMOKE_LUT[in_data.smoke_level];
            tail_reg[0].solid <= in_data.solid_cell;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp to [min, max - epsilon]; the ceiling wins if inverted
    // ------------------------------------------------------------------
    logic signed [DW-1:0] p_ext;
    logic signed [DW-1:0] v_low;
    logic signed [DW-1:0] v_reg;

    assign p_ext = DW'(p_reg);
    assign v_low = (p_ext < min_ext) ? min_ext : p_ext;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            v_reg       <= (v_low > hi_reg) ? hi_reg : v_low;
            tail_reg[1] <= tail_reg[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: offset from the low end
    // ------------------------------------------------------------------
    logic signed [DW-1:0] n_off_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            n_off_reg   <= v_reg - min_ext;
            tail_reg[2] <= tail_reg[1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: fold the sign of a negative span into the numerator
    // ------------------------------------------------------------------
    logic signed [DW-1:0] n_abs_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            n_abs_reg   <= span_neg_reg ? -n_off_reg : n_off_reg;
            tail_reg[3] <= tail_reg[2];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: classify; only 0 < n < span goes through the divider
    // ------------------------------------------------------------------
    logic [DW-1:0]        rem_reg [NORM_BITS+1];
    logic [NORM_BITS-1:0] q_reg   [NORM_BITS+1];
    norm_code_t           code_next;
    tail_t                tail_class;

    always_comb
    begin
        if (span_zero_reg)
        begin
            code_next = NORM_HALF;
        end
        else if (n_abs_reg <= 0)
        begin
            code_next = NORM_ZERO;
        end
        else if ($unsigned(n_abs_reg) >= span_abs_reg)
        begin
            code_next = NORM_TOP;
        end
        else
        begin
            code_next = NORM_DIV;
        end
    end

    // Carry the side data forward with the class code filled in.
    always_comb
    begin
        tail_class      = tail_reg[DIV_FIRST-1];
        tail_class.code = code_next;
    end

    always_ff @(posedge clk)
    begin
        if (load[DIV_FIRST])
        begin
            rem_reg[0]          <= $unsigned(n_abs_reg);
            q_reg[0]            <= '0;
            tail_reg[DIV_FIRST] <= tail_class;
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 .. 4+NORM_BITS: one restoring quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar j = 1; j <= NORM_BITS; j++)
    begin : g_div
        logic [DW-1:0] rem_shift;
        logic          take;

        assign rem_shift = {rem_reg[j-1][DW-2:0], 1'b0};
        assign take      = (rem_shift >= span_abs_reg);

        always_ff @(posedge clk)
        begin
            if (load[DIV_FIRST+j])
            begin
                rem_reg[j]            <= take ? (rem_shift - span_abs_reg) : rem_shift;
                q_reg[j]              <= {q_reg[j-1][NORM_BITS-2:0], take};
                tail_reg[DIV_FIRST+j] <= tail_reg[DIV_FIRST+j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Last stage: ramp lookup, smoke shading, output register
    // ------------------------------------------------------------------
    tail_t                  tail_last;
    logic [NORM_BITS-1:0]   u;
    logic [COLOR_WIDTH-1:0] frac;
    logic [COLOR_WIDTH-1:0] full;
    logic [COLOR_WIDTH-1:0] ramp_r;
    logic [COLOR_WIDTH-1:0] ramp_g;
    logic [COLOR_WIDTH-1:0] ramp_b;
    out_item_t              color_next;
    out_item_t              out_data_reg;

    assign tail_last = tail_reg[NS-2];
    assign full      = COLOR_WIDTH'(CMAX);
    assign frac      = u[COLOR_WIDTH-1:0];

    always_comb
    begin
        case (tail_last.code)
            NORM_ZERO: u = '0;
            NORM_TOP:  u = '1;
            NORM_HALF: u = NORM_BITS'(1) << (NORM_BITS - 1);
            default:   u = q_reg[NORM_BITS];
        endcase
    end

    // Four ramps: blue->cyan, cyan->green, green->yellow, yellow->red.
    always_comb
    begin
        case (u[NORM_BITS-1:COLOR_WIDTH])
            2'd0:
            begin
                ramp_r = '0;
                ramp_g = frac;
                ramp_b = full;
            end
            2'd1:
            begin
                ramp_r = '0;
                ramp_g = full;
                ramp_b = full - frac;
            end
            2'd2:
            begin
                ramp_r = frac;
                ramp_g = full;
                ramp_b = '0;
            end
            default:
            begin
                ramp_r = full;
                ramp_g = full - frac;
                ramp_b = '0;
            end
        endcase
    end

    always_comb
    begin
        if (show_pressure_reg)
        begin
            color_next.red   = ramp_r;
            color_next.green = ramp_g;
            color_next.blue  = ramp_b;
            if (show_smoke_reg)
            begin
                // darken each channel by the smoke level, floor at zero
                color_next.red   = (ramp_r > tail_last.smoke) ? ramp_r - tail_last.smoke : '0;
                color_next.green = (ramp_g > tail_last.smoke) ? ramp_g - tail_last.smoke : '0;
                color_next.blue  = (ramp_b > tail_last.smoke) ? ramp_b - tail_last.smoke : '0;
            end
        end
        else if (show_smoke_reg)
        begin
            color_next.red   = tail_last.smoke;
            color_next.green = tail_last.smoke;
            color_next.blue  = tail_last.smoke;
        end
        else if (tail_last.solid)
        begin
            color_next = '0;
        end
        else
        begin
            color_next.red   = full;
            color_next.green = full;
            color_next.blue  = full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[NS-1])
        begin
            out_data_reg <= color_next;
        end
    end

    assign out_data = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty output stage must leave the whole pipe free to take a transfer.
    `SFCS_ASSERT_IMPLY(a_ready_when_drained, !out_valid, in_ready,
        "input stalled with an empty output stage")
    // Every jet ramp keeps red or blue at zero; smoke only lowers channels.
    `SFCS_ASSERT_IMPLY(a_ramp_red_blue, out_valid && show_pressure_reg,
        (out_data.red == '0) || (out_data.blue == '0),
        "pressure color has both red and blue lit")
    // Grey, black and white modes give equal channels.
    `SFCS_ASSERT_IMPLY(a_grey_modes, out_valid && !show_pressure_reg,
        (out_data.red == out_data.green) && (out_data.green == out_data.blue),
        "non-pressure color is not grey")
    // An empty capture stage always takes a transfer.
    `SFCS_ASSERT_ALWAYS(a_ready_matches_output, in_ready || valid_reg[0],
        "input stalled while the capture stage is empty")

endmodule
